// File: hdl/sfcs_pkg.sv
// Shared types, codes and result builders for the SPI NOR flash command sequencer.
package sfcs_pkg;

  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] flash_address;
    logic [7:0]  write_byte;
    logic [7:0]  spi_rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] spi_tx_byte;
    logic       frame_end;
    logic [7:0] host_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } seq_res_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ID,
    PH_WREN,
    PH_HDR,
    PH_RDATA,
    PH_WDATA,
    PH_POLL_CMD,
    PH_POLL_RD
  } phase_t;

  typedef enum logic [1:0] {
    OP_ID,
    OP_READ,
    OP_WRITE,
    OP_ERASE
  } op_t;

  localparam logic [2:0] CMD_READ_ID  = 3'd0;
  localparam logic [2:0] CMD_READ     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_ERASE    = 3'd3;
  localparam logic [2:0] CMD_SPI_DONE = 3'd4;

  localparam logic [1:0] KIND_SPI  = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_BUSY = 2'd3;

  localparam logic REG_BURST = 1'b0;
  localparam logic REG_ERASE = 1'b1;

  localparam logic [7:0] OPC_RDID  = 8'h9F;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_PROG  = 8'h02;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] DUMMY     = 8'h00;

  localparam logic [8:0] BURST_RESET = 9'd16;
  localparam logic [8:0] BURST_MAX   = 9'd256;
  localparam logic [7:0] ERASE_RESET = 8'h20;

  function automatic out_item_t mk_spi(input logic [7:0] tx, input logic fe);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_SPI;
    r.spi_tx_byte = tx;
    r.frame_end   = fe;
    return r;
  endfunction

  function automatic out_item_t mk_host(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_HOST;
    r.host_byte   = b;
    return r;
  endfunction

  function automatic out_item_t mk_done(input logic fe);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_DONE;
    r.frame_end   = fe;
    return r;
  endfunction

  function automatic out_item_t mk_busy();
    out_item_t r;
    r = '0;
    r.result_kind = KIND_BUSY;
    return r;
  endfunction

endpackage

// File: hdl/sfcs_rfifo.sv
// Result queue taking up to two beats per cycle and handing out one per cycle while out_stall is low.
module sfcs_rfifo import sfcs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  out_item_t  push_first,
  input  out_item_t  push_second,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t         slots [DEPTH];
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     wr_ptr_1;
  logic [PW-1:0]     wr_ptr_next;
  logic [CW-1:0]     count;
  logic              pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr_1  = ptr_inc(wr_ptr);
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= CW'(DEPTH - 2));

  always_comb begin
    case (push_count)
      2'd1:    wr_ptr_next = wr_ptr_1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wr_ptr] <= push_first;
    if (push_count == 2'd2) slots[wr_ptr_1] <= push_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(push_count) - CW'(pop);
    end
  end

endmodule

// File: hdl/sfcs_core.sv
// Sequencer state and per-item result decision.
module sfcs_core import sfcs_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  in_item_t   item,
  input  logic [8:0] burst_len,
  input  logic [7:0] erase_op,
  output seq_res_t   res
);

  localparam int AB_RAW = (ADDR_BITS + 7) / 8;
  localparam int AB_CLAMP = (AB_RAW < 1) ? 1 : ((AB_RAW > 4) ? 4 : AB_RAW);
  localparam logic [8:0] ADDR_BYTES = 9'(AB_CLAMP);

  phase_t      phase, phase_next;
  op_t         operation, operation_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [23:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;

  logic [8:0]  burst;
  logic [1:0]  sel;
  logic [7:0]  addr_byte;
  logic        busy;
  logic        is_req;
  logic        is_spi;

  assign busy   = (phase != PH_IDLE);
  assign is_req = !item.command[2];
  assign is_spi = (item.command == CMD_SPI_DONE);

  always_comb begin
    if (burst_len == 9'd0) burst = 9'd1;
    else if (burst_len > BURST_MAX) burst = BURST_MAX;
    else burst = burst_len;
  end

  assign sel = byte_count[1:0] - 2'd1;

  always_comb begin
    case (sel)
      2'd0:    addr_byte = held_address[7:0];
      2'd1:    addr_byte = held_address[15:8];
      2'd2:    addr_byte = held_address[23:16];
      default: addr_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    operation_next    = operation;
    byte_count_next   = byte_count;
    held_address_next = held_address;
    held_data_next    = held_data;
    if (go && is_req && !busy) begin
      operation_next    = op_t'(item.command[1:0]);
      held_address_next = item.flash_address;
      held_data_next    = item.write_byte;
      unique case (item.command)
        CMD_READ_ID: begin
          byte_count_next = 9'd0;
          phase_next      = PH_ID;
        end
        CMD_READ: begin
          byte_count_next = ADDR_BYTES;
          phase_next      = PH_HDR;
        end
        default: begin
          byte_count_next = 9'd0;
          phase_next      = PH_WREN;
        end
      endcase
    end else if (go && is_spi && busy) begin
      unique case (phase)
        PH_ID: begin
          if (byte_count < 9'd3) byte_count_next = byte_count + 9'd1;
          else phase_next = PH_IDLE;
        end
        PH_WREN: begin
          byte_count_next = ADDR_BYTES;
          phase_next      = PH_HDR;
        end
        PH_HDR: begin
          if (byte_count != 9'd0) begin
            byte_count_next = byte_count - 9'd1;
          end else if (operation == OP_READ) begin
            byte_count_next = burst;
            phase_next      = PH_RDATA;
          end else if (operation == OP_WRITE) begin
            phase_next = PH_WDATA;
          end else begin
            phase_next = PH_POLL_CMD;
          end
        end
        PH_RDATA: begin
          if (byte_count > 9'd1) begin
            byte_count_next = byte_count - 9'd1;
          end else begin
            byte_count_next = 9'd0;
            phase_next      = PH_IDLE;
          end
        end
        PH_WDATA:    phase_next = PH_POLL_CMD;
        PH_POLL_CMD: phase_next = PH_POLL_RD;
        PH_POLL_RD:  phase_next = item.spi_rx_byte[0] ? PH_POLL_CMD : PH_IDLE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res = '0;
    if (is_req) begin
      res.count = 2'd1;
      if (busy) begin
        res.first = mk_busy();
      end else begin
        unique case (item.command)
          CMD_READ_ID: res.first = mk_spi(OPC_RDID, 1'b0);
          CMD_READ:    res.first = mk_spi(OPC_READ, 1'b0);
          default:     res.first = mk_spi(OPC_WREN, 1'b1);
        endcase
      end
    end else if (is_spi && busy) begin
      unique case (phase)
        PH_ID: begin
          if (byte_count == 9'd0) begin
            res.count = 2'd1;
            res.first = mk_spi(DUMMY, 1'b0);
          end else if (byte_count < 9'd3) begin
            res.count  = 2'd2;
            res.first  = mk_host(item.spi_rx_byte);
            res.second = mk_spi(DUMMY, byte_count == 9'd2);
          end else begin
            res.count  = 2'd2;
            res.first  = mk_host(item.spi_rx_byte);
            res.second = mk_done(1'b0);
          end
        end
        PH_WREN: begin
          res.count = 2'd1;
          res.first = mk_spi((operation == OP_ERASE) ? erase_op : OPC_PROG, 1'b0);
        end
        PH_HDR: begin
          res.count = 2'd1;
          if (byte_count != 9'd0)
            res.first = mk_spi(addr_byte, (byte_count == 9'd1) && (operation == OP_ERASE));
          else if (operation == OP_READ)
            res.first = mk_spi(DUMMY, burst == 9'd1);
          else if (operation == OP_WRITE)
            res.first = mk_spi(held_data, 1'b1);
          else
            res.first = mk_spi(OPC_RDSR, 1'b0);
        end
        PH_RDATA: begin
          res.count = 2'd2;
          res.first = mk_host(item.spi_rx_byte);
          if (byte_count > 9'd1) res.second = mk_spi(DUMMY, byte_count == 9'd2);
          else res.second = mk_done(1'b0);
        end
        PH_WDATA: begin
          res.count = 2'd1;
          res.first = mk_spi(OPC_RDSR, 1'b0);
        end
        PH_POLL_CMD: begin
          res.count = 2'd1;
          res.first = mk_spi(DUMMY, 1'b0);
        end
        PH_POLL_RD: begin
          res.count = 2'd1;
          if (item.spi_rx_byte[0]) res.first = mk_spi(OPC_RDSR, 1'b0);
          else res.first = mk_done(1'b1);
        end
        default: res.count = 2'd0;
      endcase
    end
    if (res.count == 2'd1) res.first.last = 1'b1;
    if (res.count == 2'd2) res.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      operation    <= OP_ID;
      byte_count   <= '0;
      held_address <= '0;
      held_data    <= '0;
    end else begin
      phase        <= phase_next;
      operation    <= operation_next;
      byte_count   <= byte_count_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
    end
  end

endmodule

// File: hdl/spi_nor_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer: register port, sequencer core, result queue.
// Each input beat is a host request (read ID, read, write byte, sector erase) or the
// completion of one SPI byte; it is decided in the cycle it is accepted and yields zero,
// one or two result beats (SPI byte to send, host data byte, done, or busy reject), which
// enter a four-entry result queue. An input beat can be taken every cycle while the queue
// has two free entries; the queue drains one beat per cycle while out_stall is low, so a
// stream of items that each give two results is held back by in_stall. Write read_burst_length (offset 0)
// and erase_opcode (offset 4) only while no operation is in progress.
module spi_nor_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int   QDEPTH    = 4;

  logic [8:0] read_burst_length;
  logic [7:0] erase_opcode;
  logic       cfg_write;
  logic       in_accept;
  logic       room;
  logic [1:0] push_count;
  seq_res_t   res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_BURST: prdata = {23'd0, read_burst_length};
      REG_ERASE: prdata = {24'd0, erase_opcode};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_burst_length <= BURST_RESET;
      erase_opcode      <= ERASE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BURST) read_burst_length <= pwdata[8:0];
      else erase_opcode <= pwdata[7:0];
    end
  end

  assign in_stall   = !room;
  assign in_accept  = in_valid && !in_stall;
  assign push_count = in_accept ? res.count : 2'd0;

  sfcs_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (in_accept),
    .item      (in_data),
    .burst_len (read_burst_length),
    .erase_op  (erase_opcode),
    .res       (res)
  );

  sfcs_rfifo #(
    .DEPTH (QDEPTH)
  ) u_rfifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (res.first),
    .push_second (res.second),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res.count != 2'd0) |=> out_valid)
    else $error("accepted item with results left the queue empty");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (res.count == 2'd2) |-> (res.second.last && !res.first.last))
    else $error("last not on the final result of a two-beat item");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (res.count == 2'd1) |-> res.first.last)
    else $error("single result not marked last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result queue not empty after reset");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SPI NOR flash command sequencer.
module tb_top import sfcs_pkg::*; ();

  localparam int ADDR_BITS  = 24;
  localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8 < 1 ? 1 :
                              (ADDR_BITS + 7) / 8 > 4 ? 4 : (ADDR_BITS + 7) / 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  phase_t      seq_phase = PH_IDLE;
  op_t         seq_op = OP_ID;
  logic [8:0]  seq_count = '0;
  logic [23:0] seq_addr = '0;
  logic [7:0]  seq_data = '0;
  logic [8:0]  burst_reg = BURST_RESET;
  logic [7:0]  erase_reg = ERASE_RESET;

  out_item_t   expected_beats[$];
  out_item_t   step_beats[$];
  int          mismatch_count = 0;
  int          items_offered = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  spi_nor_flash_command_sequencer #(.ADDR_BITS(ADDR_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_beat(logic [1:0] kind, logic [7:0] tx, logic fe,
                                     logic [7:0] host);
    out_item_t b;
    b = '0;
    b.result_kind = kind;
    b.spi_tx_byte = tx;
    b.frame_end   = fe;
    b.host_byte   = host;
    step_beats.push_back(b);
  endfunction

  function automatic void step_sequencer(in_item_t it);
    logic [31:0] wide_addr;
    logic [31:0] shifted;
    logic [8:0]  n;
    out_item_t   tail;
    int          sh;
    step_beats.delete();
    wide_addr = {8'h00, seq_addr};
    if (it.command <= CMD_ERASE) begin
      if (seq_phase != PH_IDLE) begin
        queue_beat(KIND_BUSY, 8'h00, 1'b0, 8'h00);
      end else begin
        seq_op   = op_t'(it.command[1:0]);
        seq_addr = it.flash_address;
        seq_data = it.write_byte;
        if (it.command == CMD_READ_ID) begin
          queue_beat(KIND_SPI, OPC_RDID, 1'b0, 8'h00);
          seq_count = '0;
          seq_phase = PH_ID;
        end else if (it.command == CMD_READ) begin
          queue_beat(KIND_SPI, OPC_READ, 1'b0, 8'h00);
          seq_count = 9'(ADDR_BYTES);
          seq_phase = PH_HDR;
        end else begin
          queue_beat(KIND_SPI, OPC_WREN, 1'b1, 8'h00);
          seq_count = '0;
          seq_phase = PH_WREN;
        end
      end
    end else if (it.command == CMD_SPI_DONE && seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_ID: begin
          if (seq_count > 0) queue_beat(KIND_HOST, 8'h00, 1'b0, it.spi_rx_byte);
          if (seq_count < 3) begin
            queue_beat(KIND_SPI, DUMMY, seq_count == 2, 8'h00);
            seq_count++;
          end else begin
            queue_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
            seq_phase = PH_IDLE;
          end
        end
        PH_WREN: begin
          queue_beat(KIND_SPI, seq_op == OP_ERASE ? erase_reg : OPC_PROG, 1'b0, 8'h00);
          seq_count = 9'(ADDR_BYTES);
          seq_phase = PH_HDR;
        end
        PH_HDR: begin
          if (seq_count > 0) begin
            sh = 8 * ((seq_count - 1) & 3);
            shifted = wide_addr >> sh;
            queue_beat(KIND_SPI, shifted[7:0], seq_count == 1 && seq_op == OP_ERASE, 8'h00);
            seq_count--;
          end else if (seq_op == OP_READ) begin
            n = burst_reg == 0 ? 9'd1 : burst_reg > BURST_MAX ? BURST_MAX : burst_reg;
            queue_beat(KIND_SPI, DUMMY, n == 1, 8'h00);
            seq_count = n;
            seq_phase = PH_RDATA;
          end else if (seq_op == OP_WRITE) begin
            queue_beat(KIND_SPI, seq_data, 1'b1, 8'h00);
            seq_phase = PH_WDATA;
          end else begin
            queue_beat(KIND_SPI, OPC_RDSR, 1'b0, 8'h00);
            seq_phase = PH_POLL_CMD;
          end
        end
        PH_RDATA: begin
          queue_beat(KIND_HOST, 8'h00, 1'b0, it.spi_rx_byte);
          if (seq_count > 1) begin
            queue_beat(KIND_SPI, DUMMY, seq_count == 2, 8'h00);
            seq_count--;
          end else begin
            queue_beat(KIND_DONE, 8'h00, 1'b0, 8'h00);
            seq_count = '0;
            seq_phase = PH_IDLE;
          end
        end
        PH_WDATA: begin
          queue_beat(KIND_SPI, OPC_RDSR, 1'b0, 8'h00);
          seq_phase = PH_POLL_CMD;
        end
        PH_POLL_CMD: begin
          queue_beat(KIND_SPI, DUMMY, 1'b0, 8'h00);
          seq_phase = PH_POLL_RD;
        end
        PH_POLL_RD: begin
          if (it.spi_rx_byte[0]) begin
            queue_beat(KIND_SPI, OPC_RDSR, 1'b0, 8'h00);
            seq_phase = PH_POLL_CMD;
          end else begin
            queue_beat(KIND_DONE, 8'h00, 1'b1, 8'h00);
            seq_phase = PH_IDLE;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last = 1'b1;
      step_beats.push_back(tail);
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic check_result_beat(input out_item_t got);
    out_item_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %h", got));
      return;
    end
    want = expected_beats.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch($sformatf("result_kind %0d, want %0d", got.result_kind,
                                want.result_kind));
    if (got.spi_tx_byte !== want.spi_tx_byte)
      report_mismatch($sformatf("spi_tx_byte %h, want %h", got.spi_tx_byte,
                                want.spi_tx_byte));
    if (got.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
    if (got.host_byte !== want.host_byte)
      report_mismatch($sformatf("host_byte %h, want %h", got.host_byte, want.host_byte));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) step_sequencer(in_data);
      if (out_valid && !out_stall) check_result_beat(out_data);
    end
  end

  function automatic logic [7:0] pick_rx();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [23:0] pick_addr();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.command       = 3'($urandom_range(7));
    it.flash_address = 24'($urandom_range(24'hFFFFFF));
    it.write_byte    = 8'($urandom_range(255));
    it.spi_rx_byte   = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t make_request(logic [2:0] cmd, logic [23:0] addr,
                                            logic [7:0] wb);
    in_item_t it;
    it = random_item();
    it.command       = cmd;
    it.flash_address = addr;
    it.write_byte    = wb;
    return it;
  endfunction

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic drain();
    pause_drained();
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_BURST) ? (val & 32'h1FF) : (val & 32'hFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_BURST) burst_reg = val[8:0];
    else erase_reg = val[7:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // run one request through to done; inject busy requests and junk codes as noise
  task automatic run_operation(input in_item_t req, input int polls, input int noise_pct);
    in_item_t it;
    int       left;
    left = polls;
    send_beat(req);
    items_offered++;
    while (seq_phase != PH_IDLE) begin
      it = random_item();
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1) == 1) begin
          it.command = 3'($urandom_range(3));
          items_offered++;
        end else begin
          it.command = 3'($urandom_range(7, 5));
        end
      end else begin
        it.command     = CMD_SPI_DONE;
        it.spi_rx_byte = pick_rx();
        if (seq_phase == PH_POLL_RD) begin
          it.spi_rx_byte[0] = (left > 0);
          if (left > 0) left--;
        end
        items_offered++;
      end
      send_beat(it);
    end
  endtask

  task automatic run_random(input int n, input int noise_pct);
    in_item_t it;
    int       start;
    int       r;
    start = items_offered;
    while (items_offered - start < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        it = random_item();
        it.command = (r < 2) ? CMD_SPI_DONE : 3'($urandom_range(7, 5));
        send_beat(it);
      end else if (r < 6) begin
        pause_drained();
      end else begin
        it = make_request(3'($urandom_range(3)), pick_addr(), 8'($urandom_range(255)));
        run_operation(it, $urandom_range(3), noise_pct);
      end
    end
  endtask

  task automatic test_ignored_inputs();
    in_item_t it;
    it = random_item();
    it.command = CMD_SPI_DONE;
    it.spi_rx_byte = 8'hFF;
    send_beat(it);
    for (int c = 5; c <= 7; c++) begin
      it = random_item();
      it.command = 3'(c);
      send_beat(it);
    end
    drain();
  endtask

  task automatic test_read_id();
    run_operation(make_request(CMD_READ_ID, 24'hFFFFFF, 8'hFF), 0, 0);
    drain();
  endtask

  task automatic test_erase_reset_opcode();
    run_operation(make_request(CMD_ERASE, 24'h000000, 8'h00), 2, 25);
    drain();
  endtask

  task automatic test_reset_settings();
    run_random(150, 5);
    drain();
  endtask

  task automatic test_write_byte();
    cfg_write(REG_ERASE, 32'hFF);
    run_operation(make_request(CMD_WRITE, 24'hFFFFFF, 8'hFF), 1, 0);
    run_operation(make_request(CMD_WRITE, 24'h000000, 8'h00), 0, 0);
    run_operation(make_request(CMD_ERASE, 24'hFFFFFF, 8'hFF), 0, 0);
    drain();
  endtask

  task automatic test_read_single();
    cfg_write(REG_BURST, 32'd1);
    run_operation(make_request(CMD_READ, 24'hFFFFFF, 8'hFF), 0, 0);
    run_operation(make_request(CMD_READ, 24'h000000, 8'h00), 0, 30);
    drain();
  endtask

  task automatic test_random_traffic(input logic [31:0] burst, input logic [31:0] opcode,
                                     input int idle, input int stall, input int n);
    cfg_write(REG_BURST, burst);
    cfg_write(REG_ERASE, opcode);
    set_idling(idle, stall);
    run_random(n, 8);
    drain();
  endtask

  task automatic test_backpressure();
    cfg_write(REG_BURST, 32'd8);
    set_idling(0, 0);
    hold_left = 400;
    run_random(80, 10);
    pause_drained();
    hold_left = 150;
    run_random(40, 0);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ignored_inputs();
    test_read_id();
    test_erase_reset_opcode();
    test_reset_settings();
    test_write_byte();
    test_read_single();
    test_random_traffic(32'd3, 32'hD8, 76, 0, 200);
    test_random_traffic(32'd1, 32'h00, 0, 76, 200);
    test_random_traffic(32'd0, 32'hFF, 31, 31, 200);
    test_random_traffic(32'h1FF, 32'($urandom_range(255)), 0, 0, 100);
    test_random_traffic(32'd256, 32'h20, 31, 31, 60);
    test_random_traffic(32'($urandom_range(9, 2)), 32'($urandom_range(255)), 31, 31, 150);
    test_backpressure();
    set_idling(0, 0);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
